@@ hdl/msot_pkg.sv @@
// Shared types and constants for the multi-slot one-shot/periodic timer.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
`timescale 1ns / 1ps

package msot_pkg;

  // Width of timer ids and of the id counter.
  localparam int ID_W = 16;

  // Cap on expiry results reported by one tick.
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  // Command codes on in_command.
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_ADD_ONE = 2'd1;
  localparam logic [1:0] CMD_ADD_PER = 2'd2;
  localparam logic [1:0] CMD_CLEAR   = 2'd3;

  // Result kinds on out_kind.
  localparam logic [1:0] KIND_ADDED   = 2'd0;
  localparam logic [1:0] KIND_NOFREE  = 2'd1;
  localparam logic [1:0] KIND_EXPIRED = 2'd2;
  localparam logic [1:0] KIND_DONE    = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the accepted command
    logic add;     // claim a free slot
    logic walk;    // process one slot of a tick or clear walk
    logic finish;  // deliver the closing result of a walk
  } msot_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_last;  // the slot being processed is the final one
  } msot_sts_t;

endpackage

@@ hdl/msot_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module msot_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  logic [WIDTH-1:0]       wdata,
  input  logic [AW-1:0]          raddr,
  output logic [WIDTH-1:0]       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/msot_ctrl.sv @@
// Controller state machine for the multi-slot timer.
// Depends on msot_pkg for the command codes and the control structs.
`timescale 1ns / 1ps

module msot_ctrl
  import msot_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_command,
  input  msot_sts_t  sts,
  output msot_ctl_t  ctl,
  output logic       busy
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ADD  = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          ctl.load = 1'b1;
          if (in_command inside {CMD_ADD_ONE, CMD_ADD_PER}) begin
            state_nxt = ST_ADD;
          end else begin
            state_nxt = ST_WALK;
          end
        end
      end
      ST_ADD: begin
        ctl.add   = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_WALK: begin
        ctl.walk = 1'b1;
        if (sts.walk_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        ctl.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

@@ hdl/msot_dp.sv @@
// Datapath of the multi-slot timer: live and periodic flags, slot memory,
// id counter, pending expiry and the result register.
// Depends on msot_pkg and msot_ram.
`timescale 1ns / 1ps

module msot_dp
  import msot_pkg::*;
#(
  parameter int SLOTS      = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  msot_ctl_t       ctl,
  output msot_sts_t       sts,
  input  logic [1:0]      in_command,
  input  logic [15:0]     in_duration,
  input  logic [ID_W-1:0] in_timer_id,
  output logic            out_valid,
  output logic [1:0]      out_kind,
  output logic [ID_W-1:0] out_result_id,
  output logic            out_last
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int WW = 2 * COUNT_BITS + ID_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
  localparam logic [47:0] CNT_MAX_W = (48'd1 << COUNT_BITS) - 48'd1;

  // Control state.
  logic [SLOTS-1:0] live_r, live_nxt;
  logic [SLOTS-1:0] per_r, per_nxt;
  logic [ID_W-1:0]  next_id_r, next_id_nxt;
  logic [IW-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Payload registers.
  logic [1:0]            cmd_r, cmd_nxt;
  logic [COUNT_BITS-1:0] dur_r, dur_nxt;
  logic [ID_W-1:0]       tid_r, tid_nxt;
  logic [ID_W-1:0]       pend_id_r, pend_id_nxt;
  logic [1:0]            out_kind_r, out_kind_nxt;
  logic [ID_W-1:0]       out_id_r, out_id_nxt;
  logic                  out_last_r, out_last_nxt;

  // Slot memory ports.
  logic            we;
  logic [IW-1:0]   waddr;
  logic [WW-1:0]   wdata;
  logic [IW-1:0]   raddr;
  logic [WW-1:0]   rdata;

  logic [COUNT_BITS-1:0] dur_sat;
  logic [ID_W-1:0]       rd_ident;
  logic [COUNT_BITS-1:0] rd_rem;
  logic [COUNT_BITS-1:0] rd_per;
  logic                  rd_expire;
  logic [IW-1:0]         free_idx;
  logic                  free_any;

  // Each memory word holds period, remaining count and id.
  msot_ram #(
    .WIDTH (WW),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_ident  = rdata[ID_W-1:0];
  assign rd_rem    = rdata[ID_W +: COUNT_BITS];
  assign rd_per    = rdata[ID_W + COUNT_BITS +: COUNT_BITS];
  assign rd_expire = (rd_rem[COUNT_BITS-1:1] == '0);

  // Durations beyond the counter range saturate.
  assign dur_sat = (48'(in_duration) > CNT_MAX_W) ? '1 : COUNT_BITS'(in_duration);

  // Lowest-numbered free slot.
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!live_r[i]) begin
        free_idx = IW'(i);
        free_any = 1'b1;
      end
    end
  end

  assign sts.walk_last = (idx_r == LAST_IDX);

  // The walk reads one slot ahead of the one being processed.
  assign raddr = (ctl.walk && !sts.walk_last) ? idx_r + IW'(1) : '0;

  // Next-state logic for every command.
  always_comb begin
    live_nxt      = live_r;
    per_nxt       = per_r;
    next_id_nxt   = next_id_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    pend_v_nxt    = pend_v_r;
    pend_id_nxt   = pend_id_r;
    cmd_nxt       = cmd_r;
    dur_nxt       = dur_r;
    tid_nxt       = tid_r;
    out_valid_nxt = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_id_nxt    = out_id_r;
    out_last_nxt  = out_last_r;
    we            = 1'b0;
    waddr         = idx_r;
    wdata         = {rd_per, rd_rem, rd_ident};

    // Capture the accepted command.
    if (ctl.load) begin
      cmd_nxt    = in_command;
      dur_nxt    = dur_sat;
      tid_nxt    = in_timer_id;
      idx_nxt    = '0;
      cnt_nxt    = '0;
      pend_v_nxt = 1'b0;
    end

    // Add: claim the lowest free slot or report that all are taken.
    if (ctl.add) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = 1'b1;
      if (free_any) begin
        live_nxt[free_idx] = 1'b1;
        per_nxt[free_idx]  = (cmd_r == CMD_ADD_PER);
        we                 = 1'b1;
        waddr              = free_idx;
        wdata              = {dur_r, dur_r, next_id_r};
        out_kind_nxt       = KIND_ADDED;
        out_id_nxt         = next_id_r;
        next_id_nxt        = next_id_r + ID_W'(1);
      end else begin
        out_kind_nxt = KIND_NOFREE;
        out_id_nxt   = '0;
      end
    end

    // Walk: one slot per cycle for clear or tick.
    if (ctl.walk) begin
      if (!sts.walk_last) begin
        idx_nxt = idx_r + IW'(1);
      end
      if (cmd_r == CMD_CLEAR) begin
        if (live_r[idx_r] && (rd_ident == tid_r)) begin
          live_nxt[idx_r] = 1'b0;
        end
      end else if (live_r[idx_r]) begin
        if (rd_expire) begin
          // Expiries past the cap are left for the next tick.
          if (cnt_r < CNT_W'(MAX_RESULTS)) begin
            // A held expiry is known not to be the final one now.
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_EXPIRED;
              out_id_nxt    = pend_id_r;
              out_last_nxt  = 1'b0;
            end
            pend_v_nxt  = 1'b1;
            pend_id_nxt = rd_ident;
            cnt_nxt     = cnt_r + CNT_W'(1);
            if (per_r[idx_r]) begin
              we    = 1'b1;
              wdata = {rd_per, rd_per, rd_ident};
            end else begin
              live_nxt[idx_r] = 1'b0;
            end
          end
        end else begin
          we    = 1'b1;
          wdata = {rd_per, rd_rem - COUNT_BITS'(1), rd_ident};
        end
      end
    end

    // Closing result: the held expiry, or a plain done.
    if (ctl.finish) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = 1'b1;
      if (pend_v_r) begin
        out_kind_nxt = KIND_EXPIRED;
        out_id_nxt   = pend_id_r;
      end else begin
        out_kind_nxt = KIND_DONE;
        out_id_nxt   = '0;
      end
      pend_v_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r      <= '0;
      per_r       <= '0;
      next_id_r   <= '0;
      idx_r       <= '0;
      cnt_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      live_r      <= live_nxt;
      per_r       <= per_nxt;
      next_id_r   <= next_id_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    dur_r      <= dur_nxt;
    tid_r      <= tid_nxt;
    pend_id_r  <= pend_id_nxt;
    out_kind_r <= out_kind_nxt;
    out_id_r   <= out_id_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_result_id = out_id_r;
  assign out_last      = out_last_r;

endmodule

@@ hdl/multi_slot_oneshot_periodic_timer.sv @@
// Multi-slot one-shot/periodic timer, top level.
// Add commands pass through the add state; the result is registered and strobed after it.
// Tick and clear walk the slot memory one slot per cycle, through the single read port
// of the slot memory.
// Expiries stream out during the walk; the final result follows the walk.
// Synchronous active-low reset frees all slots and zeroes the id counter.
`timescale 1ns / 1ps

module multi_slot_oneshot_periodic_timer
  import msot_pkg::*;
#(
  parameter int SLOTS      = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  logic [1:0]      in_command,
  input  logic [15:0]     in_duration,
  input  logic [ID_W-1:0] in_timer_id,
  output logic            out_valid,
  output logic [1:0]      out_kind,
  output logic [ID_W-1:0] out_result_id,
  output logic            out_last
);

  msot_ctl_t ctl;
  msot_sts_t sts;

  // Command sequencing.
  msot_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .sts        (sts),
    .ctl        (ctl),
    .busy       (busy)
  );

  // Slot state and result generation.
  msot_dp #(
    .SLOTS      (SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .sts           (sts),
    .in_command    (in_command),
    .in_duration   (in_duration),
    .in_timer_id   (in_timer_id),
    .out_valid     (out_valid),
    .out_kind      (out_kind),
    .out_result_id (out_result_id),
    .out_last      (out_last)
  );

endmodule

@@ hdl/msot_chk.sv @@
// Port-level checker for the multi-slot timer, bound to the top level.
// Depends on msot_pkg for the result kind codes.
`timescale 1ns / 1ps

module msot_chk
  import msot_pkg::*;
(
  input logic            clk,
  input logic            rst_n,
  input logic            start,
  input logic            busy,
  input logic            out_valid,
  input logic [1:0]      out_kind,
  input logic [ID_W-1:0] out_result_id,
  input logic            out_last
);

  // Reset leaves the block idle with no result on the ports.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("block not idle after reset");

  // An accepted command keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transfer did not make the block busy");

  // Only expiries can be followed by more results of the same command.
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind != KIND_EXPIRED)) |-> out_last)
    else $error("non-expiry result without last");

  // No-free and done results carry id zero.
  a_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((out_kind == KIND_NOFREE) || (out_kind == KIND_DONE)))
      |-> (out_result_id == '0))
    else $error("nonzero id on a no-free or done result");

  // A result that is not last is always followed by another result.
  a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> busy)
    else $error("result stream ended without a last transfer");

endmodule

bind multi_slot_oneshot_periodic_timer msot_chk u_chk (.*);

@@ bench/msot_timer_checker.sv @@
// Checker for the multi-slot one-shot/periodic timer: predicts and compares results.
// It mirrors the slot table from the accepted command transfers and checks each result.
// Depends on msot_pkg for the command codes, the result kinds and the id width.
`timescale 1ns / 1ps

module msot_timer_checker
  import msot_pkg::*;
#(
  parameter int SLOTS      = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            busy,
  input  logic [1:0]      in_command,
  input  logic [15:0]     in_duration,
  input  logic [ID_W-1:0] in_timer_id,
  input  logic            out_valid,
  input  logic [1:0]      out_kind,
  input  logic [ID_W-1:0] out_result_id,
  input  logic            out_last,
  output int              mismatch_count,
  output int              open_events
);

  localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 1;

  typedef struct packed {
    logic [1:0]      kind;
    logic [ID_W-1:0] id;
    logic            last;
  } timer_event_t;

  // Shadow copy of the slot table.
  logic                  armed      [SLOTS];
  logic                  repeating  [SLOTS];
  logic [COUNT_BITS-1:0] reload_val [SLOTS];
  logic [COUNT_BITS:0]   countdown  [SLOTS];
  logic [ID_W-1:0]       owner_id   [SLOTS];
  logic [ID_W-1:0]       id_counter;

  // Results still to come, oldest first.
  timer_event_t expected_events[$];

  task automatic push_event(logic [1:0] kind, logic [ID_W-1:0] id, logic last);
    timer_event_t ev;
    ev.kind = kind;
    ev.id   = id;
    ev.last = last;
    expected_events = {expected_events, ev};
  endtask

  // Apply one accepted command to the shadow table and queue its results.
  task automatic predict_command(logic [1:0] cmd, logic [15:0] dur, logic [ID_W-1:0] tid);
    int s;
    int free_slot;
    int fired;
    longint unsigned span;
    span = 64'(dur);
    if (span > COUNT_MAX) begin
      span = COUNT_MAX;
    end
    case (cmd)
      CMD_ADD_ONE, CMD_ADD_PER: begin
        free_slot = -1;
        for (s = 0; s < SLOTS; s++) begin
          if (!armed[s] && free_slot < 0) begin
            free_slot = s;
          end
        end
        if (free_slot < 0) begin
          push_event(KIND_NOFREE, '0, 1'b1);
        end else begin
          armed[free_slot]      = 1'b1;
          repeating[free_slot]  = (cmd == CMD_ADD_PER);
          reload_val[free_slot] = span[COUNT_BITS-1:0];
          countdown[free_slot]  = {1'b0, span[COUNT_BITS-1:0]};
          owner_id[free_slot]   = id_counter;
          push_event(KIND_ADDED, id_counter, 1'b1);
          id_counter = id_counter + ID_W'(1);
        end
      end
      CMD_CLEAR: begin
        for (s = 0; s < SLOTS; s++) begin
          if (armed[s] && owner_id[s] == tid) begin
            armed[s] = 1'b0;
          end
        end
        push_event(KIND_DONE, '0, 1'b1);
      end
      default: begin
        // Tick: walk the slots in index order, expiring those at one or below.
        fired = 0;
        for (s = 0; s < SLOTS; s++) begin
          if (armed[s]) begin
            if (countdown[s] <= (COUNT_BITS + 1)'(1)) begin
              if (fired < MAX_RESULTS) begin
                push_event(KIND_EXPIRED, owner_id[s], 1'b0);
                fired++;
                if (repeating[s]) begin
                  countdown[s] = {1'b0, reload_val[s]};
                end else begin
                  armed[s] = 1'b0;
                end
              end
            end else begin
              countdown[s] = countdown[s] - (COUNT_BITS + 1)'(1);
            end
          end
        end
        if (fired == 0) begin
          push_event(KIND_DONE, '0, 1'b1);
        end else begin
          expected_events[expected_events.size() - 1].last = 1'b1;
        end
      end
    endcase
  endtask

  // Compare one result transfer with the oldest expectation.
  task automatic check_result();
    timer_event_t want;
    if (expected_events.size() == 0) begin
      $error("unexpected result: kind %0d, id %0d, last %0d", out_kind, out_result_id,
             out_last);
      mismatch_count++;
    end else begin
      want = expected_events.pop_front();
      if (out_kind !== want.kind) begin
        $error("out_kind: expected %0d, actual %0d", want.kind, out_kind);
        mismatch_count++;
      end
      if (out_result_id !== want.id) begin
        $error("out_result_id: expected %0d, actual %0d", want.id, out_result_id);
        mismatch_count++;
      end
      if (out_last !== want.last) begin
        $error("out_last: expected %0d, actual %0d", want.last, out_last);
        mismatch_count++;
      end
    end
  endtask

  // Results are checked before new commands are predicted in the same cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SLOTS; s++) begin
        armed[s]     = 1'b0;
        repeating[s] = 1'b0;
      end
      id_counter = '0;
      expected_events.delete();
    end else begin
      if (out_valid) begin
        check_result();
      end
      if (start && !busy) begin
        predict_command(in_command, in_duration, in_timer_id);
      end
    end
    open_events <= expected_events.size();
  end

endmodule

@@ bench/tb.sv @@
// Testbench top for the multi-slot one-shot/periodic timer: clock, reset and stimulus.
// Drives directed and random command transfers; msot_timer_checker does the checking.
// Depends on msot_pkg, multi_slot_oneshot_periodic_timer and msot_timer_checker.
`timescale 1ns / 1ps

module tb
  import msot_pkg::*;
;

  localparam int SLOTS        = 16;
  localparam int COUNT_BITS   = 16;
  localparam int RANDOM_ITEMS = 300;

  logic            clk;
  logic            rst_n;
  logic            start;
  logic            busy;
  logic [1:0]      in_command;
  logic [15:0]     in_duration;
  logic [ID_W-1:0] in_timer_id;
  logic            out_valid;
  logic [1:0]      out_kind;
  logic [ID_W-1:0] out_result_id;
  logic            out_last;
  int              mismatch_count;
  int              open_events;

  // Add commands sent so far; a rough guide to which ids are live.
  int              adds_sent;
  int              burst_left;

  multi_slot_oneshot_periodic_timer #(
    .SLOTS      (SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_command    (in_command),
    .in_duration   (in_duration),
    .in_timer_id   (in_timer_id),
    .out_valid     (out_valid),
    .out_kind      (out_kind),
    .out_result_id (out_result_id),
    .out_last      (out_last)
  );

  msot_timer_checker #(
    .SLOTS      (SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) checker_inst (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_duration    (in_duration),
    .in_timer_id    (in_timer_id),
    .out_valid      (out_valid),
    .out_kind       (out_kind),
    .out_result_id  (out_result_id),
    .out_last       (out_last),
    .mismatch_count (mismatch_count),
    .open_events    (open_events)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Present one command and hold it until the transfer completes.
  task automatic send_command(logic [1:0] cmd, logic [15:0] dur, logic [ID_W-1:0] tid);
    start       <= 1'b1;
    in_command  <= cmd;
    in_duration <= dur;
    in_timer_id <= tid;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    if (cmd == CMD_ADD_ONE || cmd == CMD_ADD_PER) begin
      adds_sent++;
    end
  endtask

  // Drop start and hold off until every expected result has come back.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (open_events != 0) begin
      @(posedge clk);
    end
  endtask

  // Sender bursts: back-to-back transfers, then a random gap.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 23);
      gap        = $urandom_range(1, 20);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Mostly short durations so that timers expire often; a few long or extreme ones.
  function automatic logic [15:0] pick_duration();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 16'($urandom_range(0, 4));
    end else if (r < 85) begin
      return 16'($urandom_range(5, 40));
    end else if (r < 95) begin
      return 16'($urandom());
    end else begin
      return (r < 98) ? 16'hFFFF : 16'h0000;
    end
  endfunction

  task automatic send_random_command();
    int              r;
    logic [1:0]      cmd;
    logic [15:0]     dur;
    logic [ID_W-1:0] tid;
    r   = $urandom_range(0, 99);
    dur = pick_duration();
    tid = ID_W'($urandom());
    if (r < 38) begin
      cmd = CMD_TICK;
    end else if (r < 58) begin
      cmd = CMD_ADD_ONE;
    end else if (r < 72) begin
      cmd = CMD_ADD_PER;
    end else begin
      cmd = CMD_CLEAR;
      // Most clears aim at recently issued ids so that they hit a live slot.
      if ($urandom_range(0, 9) < 7) begin
        tid = ID_W'(adds_sent - $urandom_range(1, 24));
      end
    end
    send_command(cmd, dur, tid);
  endtask

  initial begin
    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_command  <= CMD_TICK;
    in_duration <= '0;
    in_timer_id <= '0;
    adds_sent   = 0;
    burst_left  = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty table, clear with no match, zero and maximum durations.
    send_command(CMD_TICK, 16'h0000, '0);
    send_command(CMD_CLEAR, 16'h0000, '1);
    send_command(CMD_ADD_ONE, 16'h0000, '0);
    send_command(CMD_TICK, 16'h0000, '0);
    send_command(CMD_ADD_PER, 16'hFFFF, '0);
    send_command(CMD_ADD_ONE, 16'h0001, '0);
    send_command(CMD_ADD_PER, 16'h0001, '0);
    // One-shot expires and is freed; the periodic one reloads and fires again.
    send_command(CMD_TICK, 16'h0000, '0);
    send_command(CMD_TICK, 16'h0000, '0);
    send_command(CMD_CLEAR, 16'h0000, ID_W'(1));
    // Fill every slot, overflow once, then expire all slots on one tick.
    for (int k = 0; k < SLOTS - 1; k++) begin
      send_command((k % 2 == 0) ? CMD_ADD_PER : CMD_ADD_ONE, 16'h0000, '0);
    end
    send_command(CMD_ADD_ONE, 16'h0005, '0);
    send_command(CMD_TICK, 16'h0000, '0);
    wait_drained();

    // Random part with bursty pacing and occasional full drains.
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      send_random_command();
      if ($urandom_range(0, 49) == 0) begin
        wait_drained();
      end else begin
        pace_sender();
      end
    end

    wait_drained();
    repeat (SLOTS + 8) @(posedge clk);
    if (mismatch_count == 0 && open_events == 0) begin
      $display("[multi_slot_oneshot_periodic_timer] OK");
    end else begin
      $display("[multi_slot_oneshot_periodic_timer] ERROR");
    end
    $finish;
  end

  // Watchdog in case the block stalls or stops producing results.
  initial begin
    #2_000_000;
    $display("[multi_slot_oneshot_periodic_timer] ERROR");
    $finish;
  end

endmodule
